// ----- rtl/core/ksc_pkg.sv -----
`default_nettype none

package ksc_pkg;

  localparam int LETTERS = 26;
  localparam int IDX_W   = 5;
  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;

  localparam logic [OP_W-1:0] OP_BEGIN = 3'd0;
  localparam logic [OP_W-1:0] OP_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_END   = 3'd2;
  localparam logic [OP_W-1:0] OP_ENC   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ = 8'h7a;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } letter_t;

  // commands from the transaction decode to the alphabet sequencer
  typedef struct packed {
    logic             clear;
    logic             place;
    logic             build;
    logic [IDX_W-1:0] letter;
  } alpha_cmd_t;

  function automatic letter_t letter_decode(input logic [CHAR_W-1:0] c);
    letter_t res;
    logic [CHAR_W-1:0] diff;
    res  = '0;
    diff = '0;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      diff    = c - CHAR_LA;
      res.hit = 1'b1;
      res.idx = diff[IDX_W-1:0];
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      diff    = c - CHAR_UA;
      res.hit = 1'b1;
      res.idx = diff[IDX_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ksc_alpha.sv -----
`default_nettype none

module ksc_alpha (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ksc_pkg::alpha_cmd_t      cmd_i,
  input  logic [ksc_pkg::IDX_W-1:0] lookup_idx_i,
  input  logic                     lookup_inv_i,
  output logic [ksc_pkg::IDX_W-1:0] lookup_o,
  output logic                     busy_o,
  output logic                     ready_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_INV  = 2'd2;

  localparam logic [ksc_pkg::IDX_W-1:0] LAST     = ksc_pkg::IDX_W'(ksc_pkg::LETTERS - 1);
  localparam logic [ksc_pkg::IDX_W-1:0] FULL_CNT = ksc_pkg::IDX_W'(ksc_pkg::LETTERS);

  logic [1:0]                    state_q, state_d;
  logic [ksc_pkg::IDX_W-1:0]     cnt_q, cnt_d;
  logic [ksc_pkg::LETTERS-1:0]   seen_q, seen_d;
  logic [ksc_pkg::IDX_W-1:0]     fill_q, fill_d;
  logic                          ready_q, ready_d;

  logic [ksc_pkg::IDX_W-1:0] fwd_q [ksc_pkg::LETTERS];
  logic [ksc_pkg::IDX_W-1:0] inv_q [ksc_pkg::LETTERS];

  logic                      place_en;
  logic [ksc_pkg::IDX_W-1:0] place_idx;
  logic                      do_place;
  logic [ksc_pkg::IDX_W-1:0] fwd_addr;
  logic [ksc_pkg::IDX_W-1:0] fwd_rd;

  // one letter slot per cycle: keyword bytes in idle, z down to a during fill
  assign place_en  = (cmd_i.place && state_q == ST_IDLE) || state_q == ST_FILL;
  assign place_idx = (state_q == ST_FILL) ? cnt_q : cmd_i.letter;
  assign do_place  = place_en && !seen_q[place_idx] && fill_q < FULL_CNT;

  assign fwd_addr = (state_q == ST_INV) ? cnt_q : lookup_idx_i;
  assign fwd_rd   = fwd_q[fwd_addr];
  assign lookup_o = lookup_inv_i ? inv_q[lookup_idx_i] : fwd_rd;

  assign busy_o  = state_q != ST_IDLE;
  assign ready_o = ready_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    seen_d  = seen_q;
    fill_d  = fill_q;
    ready_d = ready_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.clear) begin
          seen_d  = '0;
          fill_d  = '0;
          ready_d = 1'b0;
        end else if (cmd_i.build) begin
          state_d = ST_FILL;
          cnt_d   = LAST;
        end
      end
      ST_FILL: begin
        if (cnt_q == '0) begin
          state_d = ST_INV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_INV: begin
        if (cnt_q == LAST) begin
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (do_place) begin
      seen_d = seen_q | (ksc_pkg::LETTERS'(1) << place_idx);
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      seen_q  <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_place) begin
      fwd_q[fill_q] <= place_idx;
    end
    // inverse walk: slot cnt holds letter fwd_rd
    if (state_q == ST_INV) begin
      inv_q[fwd_rd] <= cnt_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/keyword_substitution_cipher_core.sv -----
// encrypt and decrypt results are registered and appear in the cycle after acceptance
// throughput: one transaction per cycle for begin, keyword, encrypt and decrypt, unless
// the output stalls; an end transaction holds the input stalled for a 26-step fill walk
// from z down to a, then a 26-step inverse-table walk, one table slot per cycle
// reset: asynchronous active low; clears letters seen, fill count, ready and output valid
`default_nettype none

module keyword_substitution_cipher_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ksc_pkg::OP_W-1:0]   opcode_i,
  input  logic [ksc_pkg::CHAR_W-1:0] char_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ksc_pkg::CHAR_W-1:0] char_out_o,
  output logic                       status_o
);

  logic                       in_acc;
  logic                       is_xlate;
  ksc_pkg::letter_t           ltr;
  ksc_pkg::alpha_cmd_t        cmd;
  logic [ksc_pkg::IDX_W-1:0]  lookup;
  logic                       busy;
  logic                       ready;

  logic                       out_valid_q, out_valid_d;
  logic [ksc_pkg::CHAR_W-1:0] char_q, char_d;
  logic                       status_q, status_d;

  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_xlate   = opcode_i == ksc_pkg::OP_ENC || opcode_i == ksc_pkg::OP_DEC;
  assign ltr        = ksc_pkg::letter_decode(char_in_i);

  always_comb begin
    cmd        = '0;
    cmd.clear  = in_acc && opcode_i == ksc_pkg::OP_BEGIN;
    cmd.place  = in_acc && opcode_i == ksc_pkg::OP_KEY && ltr.hit;
    cmd.build  = in_acc && opcode_i == ksc_pkg::OP_END;
    cmd.letter = ltr.idx;
  end

  ksc_alpha u_alpha (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .lookup_idx_i (ltr.idx),
    .lookup_inv_i (opcode_i == ksc_pkg::OP_DEC),
    .lookup_o     (lookup),
    .busy_o       (busy),
    .ready_o      (ready)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    status_d    = status_q;
    if (in_acc && is_xlate) begin
      out_valid_d = 1'b1;
      status_d    = !ready;
      if (ready && ltr.hit) begin
        char_d = ksc_pkg::CHAR_UA + ksc_pkg::CHAR_W'(lookup);
      end else begin
        char_d = char_in_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("input taken while alphabet walk runs");

  a_end_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == ksc_pkg::OP_END) |=> busy)
    else $error("end transaction did not start the fill walk");

  a_xlate_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_xlate) |=> out_valid_o)
    else $error("encrypt or decrypt gave no result");

  a_ok_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_xlate && ready && ltr.hit) |=>
      (char_out_o >= ksc_pkg::CHAR_UA && char_out_o <= ksc_pkg::CHAR_UZ && !status_o))
    else $error("substituted letter out of range");
`endif

endmodule

`default_nettype wire
